FILE: src/bfa_pkg.sv
// Shared constants, result codes and controller/datapath handshake types for the allocator.
package bfa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 10;

  localparam int unsigned CAP_W     = 10;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned FREED_W   = 5;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 10'd200;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_REUSED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_APPENDED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE_DONE  = 3'd4;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } bfa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic no_space;
    logic empty;
    logic scan_last;
  } bfa_stat_t;

endpackage

FILE: src/bfa_ctrl.sv
// Controller state machine: accept, check, table scan, drain and commit sequencing.
module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  bfa_stat_t stat_i,
  output bfa_cmd_t  cmd_o,
  output logic      busy_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.issue   = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((stat_i.no_space && !stat_i.is_free) || stat_i.empty) begin
          state_d = S_COMMIT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: src/bfa_datapath.sv
// Datapath: block table memory, best-fit search, free sweep, totals and result registers.
module bfa_datapath
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = SIZE_BITS_DEF
)(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfa_cmd_t             cmd_i,
  output bfa_stat_t            stat_o,
  input  logic                 kind_i,
  input  logic [SIZE_BITS-1:0] req_size_i,
  input  logic                 cfg_we_i,
  input  logic [CAP_W-1:0]     cfg_wdata_i,
  output logic                 done_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [CAP_W-1:0]     available_o,
  output logic [FREED_W-1:0]   freed_count_o
);

  localparam int unsigned IW   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW   = ((SIZE_BITS > CAP_W) ? SIZE_BITS : CAP_W) + 1;

  logic [SIZE_BITS:0]   mem_q [MAX_BLOCKS];
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [SIZE_BITS:0]   mem_wdata;

  logic                 kind_q;
  logic [SIZE_BITS-1:0] req_q;
  logic [CAP_W-1:0]     capacity_q;
  logic [CNTW-1:0]      count_q, count_d;
  logic [SIZE_BITS-1:0] occ_q, occ_d;
  logic [IW-1:0]        scan_idx_q;
  logic                 rd_valid_q;
  logic [IW-1:0]        rd_idx_q;
  logic [SIZE_BITS:0]   rd_data_q;
  logic                 found_q, found_d;
  logic [IW-1:0]        best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0] best_size_q, best_size_d;
  logic [CNTW-1:0]      freed_q, freed_d;

  logic                 done_q;
  logic [STATUS_W-1:0]  status_q;
  logic [IW-1:0]        slot_q;
  logic [CAP_W-1:0]     avail_q;
  logic [CNTW-1:0]      freed_out_q;

  logic                 entry_free;
  logic [SIZE_BITS-1:0] entry_size;
  logic                 no_space;
  logic                 table_full;
  logic                 alloc_ok;
  logic [STATUS_W-1:0]  res_status;
  logic [IW-1:0]        res_slot;
  logic [CNTW-1:0]      res_freed;
  logic [CW-1:0]        avail_diff;
  logic [CAP_W-1:0]     avail_next;

  assign entry_free = rd_data_q[SIZE_BITS];
  assign entry_size = rd_data_q[SIZE_BITS-1:0];
  assign no_space   = (CW'(occ_q) + CW'(req_q)) > CW'(capacity_q);
  assign table_full = (count_q == CNTW'(MAX_BLOCKS));

  assign stat_o.is_free   = (kind_q == KIND_FREE);
  assign stat_o.no_space  = no_space;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.scan_last = (CNTW'(scan_idx_q) == (count_q - CNTW'(1)));

  always_comb begin
    occ_d       = occ_q;
    count_d     = count_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_size_d = best_size_q;
    freed_d     = freed_q;
    mem_we      = 1'b0;
    mem_waddr   = rd_idx_q;
    mem_wdata   = {1'b1, entry_size};
    if (cmd_i.load) begin
      found_d = 1'b0;
      freed_d = '0;
    end
    if (rd_valid_q) begin
      if (kind_q == KIND_FREE) begin
        if (!entry_free && (entry_size == req_q)) begin
          mem_we  = 1'b1;
          occ_d   = (occ_q > req_q) ? (occ_q - req_q) : '0;
          freed_d = freed_q + CNTW'(1);
        end
      end else if (entry_free && (entry_size >= req_q) &&
                   (!found_q || (entry_size < best_size_q))) begin
        found_d     = 1'b1;
        best_idx_d  = rd_idx_q;
        best_size_d = entry_size;
      end
    end

    res_status = ST_FREE_DONE;
    res_slot   = '0;
    res_freed  = freed_q;
    alloc_ok   = 1'b0;
    if (kind_q == KIND_ALLOC) begin
      res_freed = '0;
      priority if (no_space) begin
        res_status = ST_NO_SPACE;
      end else if (found_q) begin
        res_status = ST_REUSED;
        res_slot   = best_idx_q;
        alloc_ok   = 1'b1;
      end else if (!table_full) begin
        res_status = ST_APPENDED;
        res_slot   = count_q[IW-1:0];
        alloc_ok   = 1'b1;
      end else begin
        res_status = ST_TABLE_FULL;
      end
    end

    if (cmd_i.commit && alloc_ok) begin
      mem_we    = 1'b1;
      mem_waddr = res_slot;
      mem_wdata = {1'b0, req_q};
      occ_d     = occ_q + req_q;
      if (!found_q) begin
        count_d = count_q + CNTW'(1);
      end
    end

    avail_diff = CW'(capacity_q) - CW'(occ_d);
    avail_next = (CW'(capacity_q) > CW'(occ_d)) ? avail_diff[CAP_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[scan_idx_q];
    rd_idx_q  <= scan_idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      req_q  <= req_size_i;
    end
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
    if (cmd_i.commit) begin
      status_q    <= res_status;
      slot_q      <= res_slot;
      avail_q     <= avail_next;
      freed_out_q <= res_freed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
      count_q    <= '0;
      occ_q      <= '0;
      scan_idx_q <= '0;
      rd_valid_q <= 1'b0;
      found_q    <= 1'b0;
      freed_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      count_q    <= count_d;
      occ_q      <= occ_d;
      rd_valid_q <= cmd_i.issue;
      found_q    <= found_d;
      freed_q    <= freed_d;
      done_q     <= cmd_i.commit;
      if (cmd_i.load) begin
        scan_idx_q <= '0;
      end else if (cmd_i.issue) begin
        scan_idx_q <= scan_idx_q + IW'(1);
      end
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_o        = SLOT_W'(slot_q);
  assign available_o   = avail_q;
  assign freed_count_o = FREED_W'(freed_out_q);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held longer than one cycle");

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (CNTW'(scan_idx_q) < count_q))
    else $error("table read issued beyond block count");

  a_scan_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && mem_we) |-> (kind_q == KIND_FREE))
    else $error("table written during an allocate scan");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (count_q <= CNTW'(MAX_BLOCKS)))
    else $error("block count exceeds table depth");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (res_status == ST_APPENDED)) |=> (count_q == $past(count_q) + CNTW'(1)))
    else $error("append did not advance block count");

endmodule

FILE: src/best_fit_block_allocator_unit.sv
// Top level of the best-fit block allocator: controller plus table datapath.
// Sequence: accept, a check state, a scan of the N table entries held at accept, a drain
// state, then commit; a rejected allocate or an empty table skips the scan and the drain.
// A new item is taken only once the unit is idle again; the scan reads the single-port table.
// Reset clears block count, occupied total and state; capacity returns to 200.
// The result strobe lasts one cycle and the receiver cannot stall it.
module best_fit_block_allocator_unit
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = SIZE_BITS_DEF
)(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 kind_i,
  input  logic [SIZE_BITS-1:0] req_size_i,
  input  logic                 cfg_we_i,
  input  logic [CAP_W-1:0]     cfg_wdata_i,
  output logic                 done_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [CAP_W-1:0]     available_o,
  output logic [FREED_W-1:0]   freed_count_o
);

  bfa_cmd_t  cmd;
  bfa_stat_t stat;

  bfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  bfa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .req_size_i    (req_size_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .available_o   (available_o),
    .freed_count_o (freed_count_o)
  );

endmodule
